@@ rtl/hfr_pkg.sv @@
// Shared types, constants and codes for the FTCS heat rod block.
package hfr_pkg;

  // Default sizes of the rod store.
  localparam int MAX_POINTS_DEF = 128;
  localparam int VALUE_BITS_DEF = 24;

  // Fixed widths of the configuration fields and the gain format.
  localparam int PTS_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam int MIN_POINTS = 3;

  // Configuration port geometry and reset values.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [PTS_W-1:0]  PTS_RESET  = PTS_W'(100);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(26214);

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_POINTS = 1'b0,
    REG_GAIN   = 1'b1
  } reg_idx_e;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Source of the store's write port when the step pipeline is not writing.
  typedef enum logic [2:0] {
    WS_NONE   = 3'd0,
    WS_CLEAR  = 3'd1,
    WS_ACCESS = 3'd2,
    WS_BOUND  = 3'd3,
    WS_TAIL   = 3'd4
  } wsel_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR   = 3'd0,
    ST_IDLE    = 3'd1,
    ST_ACCESS  = 3'd2,
    ST_STEP_RD = 3'd3,
    ST_DRAIN   = 3'd4,
    ST_TAIL    = 3'd5,
    ST_FINISH  = 3'd6
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  in_take;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  rd_step;
    wsel_e wsel;
    logic  sat_clr;
    logic  out_load;
  } hfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic idx_bad;
    logic cnt_zero;
    logic clr_last;
    logic step_last;
    logic pipe_empty;
    logic out_free;
  } hfr_stat_t;

endpackage

@@ rtl/hfr_regs.sv @@
// APB configuration registers: point count and diffusion gain.
module hfr_regs
  import hfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [PTS_W-1:0]      points_o,
  output logic [GAIN_W-1:0]     gain_o
);

  logic [PTS_W-1:0]  points_q;
  logic [GAIN_W-1:0] gain_q;
  logic              wr_en;
  reg_idx_e          sel_reg;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign sel_reg = reg_idx_e'(paddr[2]);

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= PTS_RESET;
      gain_q   <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (sel_reg)
        REG_POINTS: points_q <= pwdata[PTS_W-1:0];
        REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (sel_reg)
      REG_POINTS: prdata = APB_DATA_W'(points_q);
      REG_GAIN:   prdata = APB_DATA_W'(gain_q);
      default:    prdata = '0;
    endcase
  end

  assign points_o = points_q;
  assign gain_o   = gain_q;

endmodule

@@ rtl/hfr_ctrl.sv @@
// Controller state machine: clear pass, request decode, step walk and result hand-off.
module hfr_ctrl
  import hfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hfr_stat_t stat_i,
  output hfr_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register; reset starts the clearing pass over the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:    if (in_valid_i) state_d = ST_ACCESS;
      ST_ACCESS:  state_d = (stat_i.op == OP_STEP) ? ST_STEP_RD : ST_FINISH;
      ST_STEP_RD: if (stat_i.step_last) state_d = ST_DRAIN;
      ST_DRAIN:   if (stat_i.pipe_empty) state_d = ST_TAIL;
      ST_TAIL:    state_d = ST_FINISH;
      ST_FINISH:  if (stat_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '{in_take: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, rd_step: 1'b0,
              wsel: WS_NONE, sat_clr: 1'b0, out_load: 1'b0};
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wsel    = WS_CLEAR;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.in_take = in_valid_i;
        cmd_o.cnt_clr = in_valid_i;
      end
      ST_ACCESS: begin
        cmd_o.sat_clr = 1'b1;
        if (stat_i.op == OP_WRITE && !stat_i.idx_bad) begin
          cmd_o.wsel = WS_ACCESS;
        end
      end
      ST_STEP_RD: begin
        // The first read of point zero sees its old value; the boundary lands with it.
        cmd_o.rd_step = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_zero) begin
          cmd_o.wsel = WS_BOUND;
        end
      end
      ST_DRAIN: ;
      ST_TAIL:   cmd_o.wsel = WS_TAIL;
      ST_FINISH: cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ rtl/hfr_dp.sv @@
// Datapath: rod store, address counter, stencil pipeline and output register.
module hfr_dp
  import hfr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS)
)(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hfr_cmd_t                     cmd_i,
  output hfr_stat_t                    stat_o,
  input  logic [PTS_W-1:0]             points_i,
  input  logic [GAIN_W-1:0]            gain_i,
  input  logic [1:0]                   command_i,
  input  logic [IDX_W-1:0]             point_index_i,
  input  logic signed [VALUE_BITS-1:0] point_value_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic                         bad_index_o,
  output logic                         saturated_o
);

  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > PTS_W) ? NW : PTS_W;
  localparam int LW = VALUE_BITS + 2;
  localparam int PW = LW + GAIN_W + 1;
  localparam int SW = VALUE_BITS + 4;

  // Latched request.
  op_e                    op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [VALUE_BITS-1:0]  val_q;

  // Store and its ports.
  logic [VALUE_BITS-1:0]  mem_q [MAX_POINTS];
  logic [VALUE_BITS-1:0]  rd_data_q;
  logic                   we;
  logic [IDX_W-1:0]       wa, ra;
  logic [VALUE_BITS-1:0]  wd;

  // Counter and point count.
  logic [IDX_W-1:0]       cnt_q;
  logic [CW-1:0]          pts_x, n_full;
  logic [NW-1:0]          n_pts, n_m1;
  logic                   idx_bad;

  // Stencil pipeline.
  logic                   rdv_q, s1v_q, s2v_q;
  logic [IDX_W-1:0]       rd_addr_q, s1_addr_q, s2_addr_q;
  logic [VALUE_BITS-1:0]  win_a_q, win_b_q;
  logic signed [LW-1:0]   lap_d, lap_q;
  logic [VALUE_BITS-1:0]  s1_y_q, s2_y_q;
  logic signed [PW-1:0]   prod_d, prod_q;
  logic signed [SW-1:0]   sum;
  logic                   clip;
  logic [VALUE_BITS-1:0]  nv;
  logic [VALUE_BITS-1:0]  last_q;
  logic                   sat_q;

  // Output register.
  logic                   out_valid_q;
  logic [VALUE_BITS-1:0]  read_value_q;
  logic                   bad_q, sat_out_q;
  logic                   out_free;

  // Active point count, held to the range three to MAX_POINTS.
  always_comb begin
    pts_x = CW'(points_i);
    if (pts_x < CW'(MIN_POINTS)) begin
      n_full = CW'(MIN_POINTS);
    end else if (pts_x > CW'(MAX_POINTS)) begin
      n_full = CW'(MAX_POINTS);
    end else begin
      n_full = pts_x;
    end
  end
  assign n_pts   = n_full[NW-1:0];
  assign n_m1    = n_pts - NW'(1);
  assign idx_bad = (op_q == OP_WRITE || op_q == OP_READ) && (NW'(idx_q) >= n_pts);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      op_q  <= op_e'(command_i);
      idx_q <= point_index_i;
      val_q <= point_value_i;
    end
  end

  // Address counter for the clearing pass and the step walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  // Write port select; the stencil write never overlaps a controller write.
  always_comb begin
    we = 1'b0;
    wa = cnt_q;
    wd = '0;
    if (s2v_q) begin
      we = 1'b1;
      wa = s2_addr_q;
      wd = nv;
    end else begin
      unique case (cmd_i.wsel)
        WS_NONE: ;
        WS_CLEAR: begin
          we = 1'b1;
          wa = cnt_q;
          wd = '0;
        end
        WS_ACCESS: begin
          we = 1'b1;
          wa = idx_q;
          wd = val_q;
        end
        WS_BOUND: begin
          we = 1'b1;
          wa = '0;
          wd = val_q;
        end
        WS_TAIL: begin
          we = 1'b1;
          wa = n_m1[IDX_W-1:0];
          wd = last_q;
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign ra = cmd_i.rd_step ? cnt_q : idx_q;

  // Rod store with registered read; a read of the address being written sees old data.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_data_q <= mem_q[ra];
  end

  // Laplacian of the center point from the sliding window of old values.
  assign lap_d = LW'($signed(win_a_q)) + LW'($signed(rd_data_q))
               - (LW'($signed(win_b_q)) <<< 1);
  assign prod_d = lap_q * $signed({1'b0, gain_i});

  // Update, floor by the gain's fraction bits, then saturate.
  assign sum  = SW'($signed(s2_y_q)) + SW'($signed(prod_q[PW-1:GAIN_FRAC]));
  assign clip = !((&sum[SW-1:VALUE_BITS-1]) || !(|sum[SW-1:VALUE_BITS-1]));
  always_comb begin
    if (!clip) begin
      nv = sum[VALUE_BITS-1:0];
    end else if (sum[SW-1]) begin
      nv = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      nv = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  // Pipeline valid bits and the sticky clip flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
      sat_q <= 1'b0;
    end else begin
      rdv_q <= cmd_i.rd_step;
      s1v_q <= rdv_q && (rd_addr_q >= IDX_W'(2));
      s2v_q <= s1v_q;
      if (cmd_i.sat_clr) begin
        sat_q <= 1'b0;
      end else if (s2v_q && clip) begin
        sat_q <= 1'b1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_step) begin
      rd_addr_q <= cnt_q;
    end
    if (rdv_q) begin
      win_a_q   <= win_b_q;
      win_b_q   <= rd_data_q;
      lap_q     <= lap_d;
      s1_y_q    <= win_b_q;
      s1_addr_q <= rd_addr_q - IDX_W'(1);
    end
    prod_q    <= prod_d;
    s2_y_q    <= s1_y_q;
    s2_addr_q <= s1_addr_q;
    if (s2v_q) begin
      last_q <= nv;
    end
  end

  // Result register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_value_q <= (op_q == OP_READ && !idx_bad) ? rd_data_q : '0;
      bad_q        <= idx_bad;
      sat_out_q    <= (op_q == OP_STEP) ? sat_q : 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign bad_index_o  = bad_q;
  assign saturated_o  = sat_out_q;

  // Status to the controller.
  assign stat_o = '{op: op_q, idx_bad: idx_bad, cnt_zero: (cnt_q == '0),
                    clr_last: (cnt_q == IDX_W'(MAX_POINTS - 1)),
                    step_last: (cnt_q == n_m1[IDX_W-1:0]),
                    pipe_empty: !(rdv_q || s1v_q || s2v_q),
                    out_free: out_free};

  // The stencil write owns the port whenever it is active.
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2v_q |-> (cmd_i.wsel == WS_NONE))
    else $error("stencil write collides with a controller write");

  // A result is loaded only when the output register can take it.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending result");

  // Every laplacian reaches the update stage in the next cycle.
  a_s1_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1v_q |=> s2v_q)
    else $error("stencil pipeline dropped a point");

  // Each step read returns data in the next cycle.
  a_rd_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_step |=> rdv_q)
    else $error("step read did not return data");

endmodule

@@ rtl/heat_ftcs_rod_step.sv @@
// Top level of the explicit FTCS heat rod: configuration, controller and datapath.
//
// A rod of MAX_POINTS signed fixed-point temperatures (Q4.20 at the default width) sits in a
// store with one write port and one registered read port. After reset the block clears every
// point of the store to zero and stalls requests meanwhile; the configuration port stays open.
// Write, read and no-op requests pass from idle through an access state to a finish state that
// loads the result once the output register is free. A step walks the store one point per
// cycle through the single read port and a three-stage stencil pipeline (laplacian, gain
// multiply, add and saturate) over the points in use, their count held to the range three to
// MAX_POINTS, then drains the pipeline and copies the last new point to the far end. A finished
// result waits in an output register, and the next request is taken while it waits.
module heat_ftcs_rod_step
  import hfr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS)
)(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [IDX_W-1:0]             point_index_i,
  input  logic signed [VALUE_BITS-1:0] point_value_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic                         bad_index_o,
  output logic                         saturated_o
);

  logic [PTS_W-1:0]  points;
  logic [GAIN_W-1:0] gain;
  hfr_cmd_t          cmd;
  hfr_stat_t         stat;

  // Configuration registers.
  hfr_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .points_o (points),
    .gain_o   (gain)
  );

  // Controller.
  hfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  hfr_dp #(
    .MAX_POINTS (MAX_POINTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .points_i      (points),
    .gain_i        (gain),
    .command_i     (command_i),
    .point_index_i (point_index_i),
    .point_value_i (point_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .read_value_o  (read_value_o),
    .bad_index_o   (bad_index_o),
    .saturated_o   (saturated_o)
  );

endmodule

@@ tb/heat_ftcs_rod_step_test.sv @@
// Self-checking testbench for the FTCS heat rod: directed table, then randomized phases.
`timescale 1ns / 100ps

module heat_ftcs_rod_step_test;
  import hfr_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS_DEF);
  localparam int VB    = VALUE_BITS_DEF;

  localparam logic signed [VB-1:0] TEMP_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] TEMP_MIN = {1'b1, {(VB-1){1'b0}}};
  localparam longint VAL_HI = (64'sd1 <<< (VB - 1)) - 1;
  localparam longint VAL_LO = -(64'sd1 <<< (VB - 1));

  localparam int NUM_PHASES     = 14;
  localparam int LISTED_PHASES  = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic signed [VB-1:0] read_value;
    logic                 bad_index;
    logic                 saturated;
  } rod_result_t;

  typedef struct packed {
    op_e                  cmd;
    logic [IDX_W-1:0]     idx;
    logic signed [VB-1:0] value;
    logic                 known;
    rod_result_t          result;
  } rod_request_t;

  localparam rod_result_t RES_ZERO = '{'0, 1'b0, 1'b0};
  localparam rod_result_t RES_BAD  = '{'0, 1'b1, 1'b0};

  // Register settings for the listed phases; the remaining phases pick theirs at random.
  localparam int PHASE_POINTS [LISTED_PHASES] =
    '{3, 128, 255, 0, 16, 2, 1, 129, 64, 5, 100, 128};
  localparam int PHASE_GAIN [LISTED_PHASES] =
    '{0, 32768, 65535, 26214, 49152, 1, 32768, 20000, 65535, 60000, 26214, 30000};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            command_i = OP_NOP;
  logic [IDX_W-1:0]      point_index_i = '0;
  logic signed [VB-1:0]  point_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [VB-1:0]  read_value_o;
  logic                  bad_index_o;
  logic                  saturated_o;

  // Shadow copy of the rod and its registers, as they stand after reset.
  logic signed [VB-1:0] rod_temp [MAX_POINTS_DEF] = '{default: '0};
  logic [PTS_W-1:0]     pts_cfg = PTS_RESET;
  logic [GAIN_W-1:0]    gain_cfg = GAIN_RESET;

  rod_result_t  pending_results [$];
  rod_request_t dir_table [25];

  bit          pacing_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;
  int unsigned req_count = 0;
  int unsigned step_count = 0;
  int unsigned clip_seen = 0;
  int unsigned bad_seen = 0;
  int unsigned cfg_writes = 0;

  heat_ftcs_rod_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .point_index_i (point_index_i),
    .point_value_i (point_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .bad_index_o   (bad_index_o),
    .saturated_o   (saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The point count in effect, held to the range the rod supports.
  function automatic int unsigned active_count();
    if (pts_cfg < MIN_POINTS) return MIN_POINTS;
    if (pts_cfg > MAX_POINTS_DEF) return MAX_POINTS_DEF;
    return pts_cfg;
  endfunction

  // Applies one request to the shadow rod and returns the result it should produce.
  function automatic rod_result_t rod_response(rod_request_t req);
    rod_result_t res;
    int unsigned n;
    int unsigned i;
    longint      left_old;
    longint      y;
    longint      lap;
    longint      nv;
    longint      g;
    logic        clipped;
    res = RES_ZERO;
    n = active_count();
    g = gain_cfg;
    clipped = 1'b0;
    case (req.cmd)
      OP_WRITE, OP_READ: begin
        if (req.idx >= n) begin
          res.bad_index = 1'b1;
        end else if (req.cmd == OP_WRITE) begin
          rod_temp[req.idx] = req.value;
        end else begin
          res.read_value = rod_temp[req.idx];
        end
      end
      OP_STEP: begin
        // Every interior point uses the values from before the step.
        left_old = rod_temp[0];
        rod_temp[0] = req.value;
        for (i = 1; i + 1 < n; i++) begin
          y = rod_temp[i];
          lap = left_old - 2 * y + rod_temp[i + 1];
          nv = y + ((lap * g) >>> GAIN_FRAC);
          if (nv > VAL_HI) begin
            nv = VAL_HI;
            clipped = 1'b1;
          end else if (nv < VAL_LO) begin
            nv = VAL_LO;
            clipped = 1'b1;
          end
          left_old = y;
          rod_temp[i] = nv[VB-1:0];
        end
        // Insulated far end copies its new neighbor.
        rod_temp[n - 1] = rod_temp[n - 2];
        res.saturated = clipped;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Presents one request, waits for it to be taken and records what it should return.
  task automatic issue_request(rod_request_t req);
    rod_result_t pred;
    int unsigned gap;
    if (pacing_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= req.cmd;
    point_index_i <= req.idx;
    point_value_i <= req.value;
    do @(posedge clk_i); while (in_stall_o);
    pred = rod_response(req);
    pending_results.push_back(req.known ? req.result : pred);
    req_count++;
    if (req.cmd == OP_STEP) step_count++;
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(reg_idx_e which, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (which == REG_POINTS) pts_cfg = data[PTS_W-1:0];
    else gain_cfg = data[GAIN_W-1:0];
    cfg_writes++;
  endtask

  // Result side: random stall bursts with open cycles between them.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= (stall_left != 0);
    end else if (pacing_on && !out_stall_i && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 17);
      out_stall_i <= 1'b1;
    end
  end

  // Compare each result taken with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    rod_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (saturated_o) clip_seen++;
      if (bad_index_o) bad_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result with none outstanding: read_value %0d bad_index %0b saturated %0b",
                 $time, read_value_o, bad_index_o, saturated_o);
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.read_value) begin
          err_count++;
          $display("%0t: read_value expected %0d, got %0d",
                   $time, want.read_value, read_value_o);
        end
        if (bad_index_o !== want.bad_index) begin
          err_count++;
          $display("%0t: bad_index expected %0b, got %0b", $time, want.bad_index, bad_index_o);
        end
        if (saturated_o !== want.saturated) begin
          err_count++;
          $display("%0t: saturated expected %0b, got %0b", $time, want.saturated, saturated_o);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rod_request_t req;
    int unsigned  ph;
    int unsigned  k;
    int unsigned  sel;
    int unsigned  n_eff;
    logic [APB_DATA_W-1:0] pts_set;
    logic [APB_DATA_W-1:0] gain_set;

    // Directed rows run with the reset register values: 100 points, gain 0.4.
    dir_table = '{
      '{OP_READ,  7'd0,   '0,           1'b1, RES_ZERO},
      '{OP_READ,  7'd127, '0,           1'b1, RES_BAD},
      '{OP_WRITE, 7'd100, 24'sh123456,  1'b1, RES_BAD},
      '{OP_NOP,   7'd85,  24'shFFFFFF,  1'b1, RES_ZERO},
      '{OP_WRITE, 7'd0,   TEMP_MAX,     1'b1, RES_ZERO},
      '{OP_READ,  7'd0,   '0,           1'b1, '{TEMP_MAX, 1'b0, 1'b0}},
      '{OP_WRITE, 7'd99,  TEMP_MIN,     1'b1, RES_ZERO},
      '{OP_READ,  7'd99,  '0,           1'b1, '{TEMP_MIN, 1'b0, 1'b0}},
      '{OP_WRITE, 7'd98,  24'shFFFFFF,  1'b1, RES_ZERO},
      '{OP_WRITE, 7'd1,   TEMP_MAX,     1'b1, RES_ZERO},
      '{OP_WRITE, 7'd2,   TEMP_MIN,     1'b1, RES_ZERO},
      '{OP_READ,  7'd100, '0,           1'b1, RES_BAD},
      '{OP_WRITE, 7'd127, TEMP_MAX,     1'b1, RES_BAD},
      '{OP_STEP,  7'd42,  TEMP_MIN,     1'b0, RES_ZERO},
      '{OP_READ,  7'd0,   '0,           1'b1, '{TEMP_MIN, 1'b0, 1'b0}},
      '{OP_READ,  7'd1,   '0,           1'b0, RES_ZERO},
      '{OP_READ,  7'd2,   '0,           1'b0, RES_ZERO},
      '{OP_READ,  7'd99,  '0,           1'b0, RES_ZERO},
      '{OP_STEP,  7'd127, TEMP_MAX,     1'b0, RES_ZERO},
      '{OP_READ,  7'd98,  '0,           1'b0, RES_ZERO},
      '{OP_READ,  7'd99,  '0,           1'b0, RES_ZERO},
      '{OP_NOP,   7'd0,   TEMP_MAX,     1'b1, RES_ZERO},
      '{OP_STEP,  7'd0,   '0,           1'b0, RES_ZERO},
      '{OP_WRITE, 7'd42,  24'sh2AAAAA,  1'b1, RES_ZERO},
      '{OP_READ,  7'd42,  '0,           1'b1, '{24'sh2AAAAA, 1'b0, 1'b0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[r]) issue_request(dir_table[r]);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // Let the rod go idle before touching the registers.
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      if (ph < LISTED_PHASES) begin
        pts_set  = PHASE_POINTS[ph];
        gain_set = PHASE_GAIN[ph];
      end else begin
        pts_set  = $urandom_range(0, 255);
        gain_set = $urandom_range(0, 65535);
      end
      // The final phase runs at full rate on both sides.
      pacing_on = (ph != NUM_PHASES - 1);
      write_register(REG_POINTS, pts_set);
      write_register(REG_GAIN, gain_set);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        n_eff = active_count();
        sel = $urandom_range(0, 99);
        if (sel < 28) req.cmd = OP_WRITE;
        else if (sel < 58) req.cmd = OP_READ;
        else if (sel < 94) req.cmd = OP_STEP;
        else req.cmd = OP_NOP;
        // Mostly indexes inside the rod, now and then anywhere.
        if ($urandom_range(0, 7) == 0) req.idx = IDX_W'($urandom_range(0, MAX_POINTS_DEF - 1));
        else req.idx = IDX_W'($urandom_range(0, n_eff - 1));
        case ($urandom_range(0, 9))
          0: req.value = TEMP_MAX;
          1: req.value = TEMP_MIN;
          2: req.value = '0;
          default: req.value = VB'($urandom());
        endcase
        req.known  = 1'b0;
        req.result = RES_ZERO;
        issue_request(req);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests, %0d of them time steps, over %0d register writes.",
             req_count, step_count, cfg_writes);
    $display("Results flagged a bad index %0d times and clipping %0d times; %0d mismatches.",
             bad_seen, clip_seen, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hfr_pkg.sv
rtl/hfr_regs.sv
rtl/hfr_ctrl.sv
rtl/hfr_dp.sv
rtl/heat_ftcs_rod_step.sv
tb/heat_ftcs_rod_step_test.sv
